// File: src/boundary_tag_heap_allocator_core_macros.svh
// Assertion macros shared by the checker file.
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_CORE_MACROS_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BTH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BTH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/bth_pkg.sv
package bth_pkg;

  localparam int WORD_W = 16;
  localparam int IDX_W  = 17;
  localparam int RUN_W  = 17;
  localparam int ADJ_W  = 17;
  localparam int BYTE_W = 14;

  localparam logic OPC_ALLOC   = 1'b0;
  localparam logic OPC_RELEASE = 1'b1;

  localparam logic [WORD_W-1:0] EVEN_MASK = 16'hFFFE;
  localparam logic [WORD_W-1:0] USED_MARK = 16'h0001;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NULL = 2'd1,
    ST_OOM  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_FP_CHK,
    S_MERGE,
    S_PLACE,
    S_MARK,
    S_SCAN,
    S_REL,
    S_TALLY_INIT,
    S_TALLY,
    S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CLEAR,
    DP_LOAD,
    DP_FP_CHK,
    DP_MERGE,
    DP_PLACE,
    DP_MARK,
    DP_SCAN,
    DP_REL,
    DP_TALLY_INIT,
    DP_TALLY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic req_release;
    logic req_bad;
    logic fp_fits;
    logic walk_more;
    logic merge_hit;
    logic rem_zero;
    logic scan_more;
  } dp_stat_t;

endpackage

// File: src/boundary_tag_heap_allocator_core.sv
// Flow: a null or wrapping size goes straight to the tally; a release clears the used mark
//   of its block; an allocate tries the block at the roving pointer, else walks the heap
//   merging free runs, then places and marks it, skipping used blocks after an exact fit.
// Every request ends in a tally walk; start is ignored while busy, high from accept through done.
// Reset: synchronous; a clearing pass over every heap word rebuilds the heap while busy is high.
// Results hold from the single cycle done is high to the next accept; the receiver cannot stall.
module boundary_tag_heap_allocator_core #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  output logic                       done,
  input  logic                       opcode,
  input  logic [bth_pkg::WORD_W-1:0] request_size,
  input  logic [bth_pkg::BYTE_W-1:0] region_address,
  output logic [1:0]                 status,
  output logic [bth_pkg::BYTE_W-1:0] granted_address,
  output logic [bth_pkg::BYTE_W-1:0] free_bytes,
  output logic [bth_pkg::BYTE_W-1:0] used_bytes
);
  import bth_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bth_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  bth_dp #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .opcode          (opcode),
    .request_size    (request_size),
    .region_address  (region_address),
    .status          (status),
    .granted_address (granted_address),
    .free_bytes      (free_bytes),
    .used_bytes      (used_bytes)
  );

endmodule

// File: src/bth_dp.sv
module bth_dp #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bth_pkg::dp_cmd_t              cmd,
  output bth_pkg::dp_stat_t             stat,
  input  logic                          opcode,
  input  logic [bth_pkg::WORD_W-1:0]    request_size,
  input  logic [bth_pkg::BYTE_W-1:0]    region_address,
  output logic [1:0]                    status,
  output logic [bth_pkg::BYTE_W-1:0]    granted_address,
  output logic [bth_pkg::BYTE_W-1:0]    free_bytes,
  output logic [bth_pkg::BYTE_W-1:0]    used_bytes
);
  import bth_pkg::*;

  localparam int AW    = $clog2(HEAP_WORDS);
  localparam int EXT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0]  HEAP_END  = IDX_W'(HEAP_WORDS);
  localparam logic [WORD_W-1:0] INIT_WORD = WORD_W'(2 * HEAP_WORDS);

  // heap store
  logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      heap_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= heap_mem[mem_raddr];
  end

  logic [IDX_W-1:0]  walk_idx;
  logic [IDX_W-1:0]  run_start;
  logic [IDX_W-1:0]  free_ptr;
  logic [IDX_W-1:0]  place_idx;
  logic [RUN_W-1:0]  run;
  logic [ADJ_W-1:0]  adj;
  logic [WORD_W-1:0] place_blk;
  logic [AW-1:0]     rel_idx;
  logic              rel_ok;
  status_t           status_q;
  logic [BYTE_W-1:0] granted_q;
  logic [BYTE_W-1:0] free_acc;
  logic [BYTE_W-1:0] used_acc;
  logic [BYTE_W-1:0] free_q;
  logic [BYTE_W-1:0] used_total;

  logic [ADJ_W-1:0]  size_sum;
  logic [ADJ_W-1:0]  adj_in;
  logic [IDX_W-1:0]  rel_word;
  logic              rel_ok_in;
  logic [WORD_W-1:0] w_walk;
  logic [WORD_W-1:0] w_fp;
  logic [WORD_W-1:0] fsize;
  logic [IDX_W-1:0]  walk_step;
  logic              walk_more;
  logic              walk_used;
  logic              run_nz;
  logic              run_fits;
  logic              run_close;
  logic              merge_hit;
  logic [EXT_W-1:0]  run_end;
  logic              fp_in_run;
  logic [WORD_W-1:0] rem;
  logic              rem_zero;
  logic [IDX_W-1:0]  place_next;
  logic [IDX_W-1:0]  place_plus;
  logic              scan_more;
  logic [IDX_W-1:0]  scan_step;
  logic [IDX_W-1:0]  rd_idx;

  assign size_sum  = ADJ_W'(request_size) + ADJ_W'(3);
  assign adj_in    = {size_sum[ADJ_W-1:1], 1'b0};
  assign rel_word  = IDX_W'(region_address[BYTE_W-1:1]) - IDX_W'(1);
  assign rel_ok_in = (region_address[BYTE_W-1:1] != '0) && (rel_word < HEAP_END);

  // words past the end of the heap read as the zero end marker
  assign w_walk    = (walk_idx < HEAP_END) ? mem_rdata : '0;
  assign w_fp      = (free_ptr < HEAP_END) ? mem_rdata : '0;
  assign fsize     = w_fp[0] ? '0 : w_fp;

  assign walk_step = walk_idx + IDX_W'(w_walk[WORD_W-1:1]);
  assign walk_more = (w_walk[WORD_W-1:1] != '0);
  assign walk_used = w_walk[0];

  assign run_nz    = (run != '0);
  assign run_fits  = (run >= RUN_W'(adj));
  assign run_close = run_nz && (!walk_more || walk_used);
  assign merge_hit = run_close && run_fits;
  assign run_end   = EXT_W'(run_start) + EXT_W'(run[RUN_W-1:1]);
  assign fp_in_run = (free_ptr > run_start) && (EXT_W'(free_ptr) < run_end);

  assign rem        = place_blk - adj[WORD_W-1:0];
  assign rem_zero   = (rem == '0);
  assign place_next = place_idx + IDX_W'(adj[ADJ_W-1:1]);
  assign place_plus = place_idx + IDX_W'(1);

  assign scan_more = w_fp[0] && (w_fp[WORD_W-1:1] != '0);
  assign scan_step = free_ptr + IDX_W'(w_fp[WORD_W-1:1]);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    rd_idx    = '0;
    unique case (cmd.op)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = walk_idx[AW-1:0];
        mem_wdata = (walk_idx == '0) ? INIT_WORD : '0;
      end
      DP_LOAD: begin
        rd_idx = (opcode == OPC_RELEASE) ? rel_word : free_ptr;
      end
      DP_MERGE: begin
        rd_idx    = walk_step;
        mem_we    = run_close;
        mem_waddr = run_start[AW-1:0];
        mem_wdata = run[WORD_W-1:0];
      end
      DP_PLACE: begin
        mem_we    = !rem_zero && (place_next < HEAP_END);
        mem_waddr = place_next[AW-1:0];
        mem_wdata = rem;
      end
      DP_MARK: begin
        mem_we    = 1'b1;
        mem_waddr = place_idx[AW-1:0];
        mem_wdata = adj[WORD_W-1:0] | USED_MARK;
        rd_idx    = free_ptr;
      end
      DP_SCAN: begin
        rd_idx = scan_step;
      end
      DP_REL: begin
        mem_we    = rel_ok;
        mem_waddr = rel_idx;
        mem_wdata = mem_rdata & EVEN_MASK;
      end
      DP_TALLY: begin
        rd_idx = walk_step;
      end
      default: begin
      end
    endcase
    mem_raddr = rd_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx   <= '0;
      free_ptr   <= '0;
      used_total <= '0;
    end else begin
      unique case (cmd.op)
        DP_CLEAR: begin
          walk_idx <= walk_idx + IDX_W'(1);
        end
        DP_FP_CHK: begin
          walk_idx <= '0;
        end
        DP_MERGE: begin
          if (walk_more) begin
            walk_idx <= walk_step;
          end
          // pull the roving pointer back when a merge swallows its block
          if (run_close && fp_in_run) begin
            free_ptr <= run_start;
          end
        end
        DP_PLACE: begin
          free_ptr <= place_next;
        end
        DP_SCAN: begin
          if (scan_more) begin
            free_ptr <= scan_step;
          end else if (free_ptr > HEAP_END) begin
            free_ptr <= HEAP_END;
          end
        end
        DP_TALLY_INIT: begin
          walk_idx <= '0;
        end
        DP_TALLY: begin
          if (walk_more) begin
            walk_idx <= walk_step;
          end else begin
            used_total <= used_acc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_LOAD: begin
        adj       <= adj_in;
        rel_idx   <= rel_word[AW-1:0];
        rel_ok    <= rel_ok_in;
        granted_q <= '0;
        if (opcode == OPC_ALLOC && request_size == '0) begin
          status_q <= ST_NULL;
        end else if (opcode == OPC_ALLOC && adj_in[ADJ_W-1]) begin
          status_q <= ST_OOM;
        end else begin
          status_q <= ST_OK;
        end
      end
      DP_FP_CHK: begin
        place_idx <= free_ptr;
        place_blk <= w_fp;
        run       <= '0;
        run_start <= '0;
      end
      DP_MERGE: begin
        if (walk_more && walk_used) begin
          run       <= '0;
          run_start <= walk_step;
        end else if (walk_more) begin
          run <= run + RUN_W'(w_walk);
        end
        if (run_close) begin
          place_idx <= run_start;
          place_blk <= run[WORD_W-1:0];
        end
        if (!walk_more && !merge_hit) begin
          status_q <= ST_OOM;
        end
      end
      DP_PLACE: begin
        granted_q <= {place_plus[BYTE_W-2:0], 1'b0};
      end
      DP_TALLY_INIT: begin
        free_acc <= '0;
        used_acc <= '0;
      end
      DP_TALLY: begin
        if (walk_more) begin
          if (walk_used) begin
            used_acc <= used_acc + {w_walk[BYTE_W-1:1], 1'b0};
          end else begin
            free_acc <= free_acc + w_walk[BYTE_W-1:0];
          end
        end else begin
          free_q <= free_acc;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.clear_last  = (walk_idx == HEAP_END - IDX_W'(1));
  assign stat.req_release = (opcode == OPC_RELEASE);
  assign stat.req_bad     = (request_size == '0) || adj_in[ADJ_W-1];
  assign stat.fp_fits     = (adj <= ADJ_W'(fsize));
  assign stat.walk_more   = walk_more;
  assign stat.merge_hit   = merge_hit;
  assign stat.rem_zero    = rem_zero;
  assign stat.scan_more   = scan_more;

  assign status          = status_q;
  assign granted_address = granted_q;
  assign free_bytes      = free_q;
  assign used_bytes      = used_total;

endmodule

// File: src/bth_ctrl.sv
module bth_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bth_pkg::dp_stat_t stat,
  output bth_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done
);
  import bth_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op = DP_LOAD;
          priority if (stat.req_release) begin
            state_next = S_REL;
          end else if (stat.req_bad) begin
            state_next = S_TALLY_INIT;
          end else begin
            state_next = S_FP_CHK;
          end
        end
      end
      S_FP_CHK: begin
        cmd.op     = DP_FP_CHK;
        state_next = stat.fp_fits ? S_PLACE : S_MERGE;
      end
      S_MERGE: begin
        cmd.op = DP_MERGE;
        priority if (stat.merge_hit) begin
          state_next = S_PLACE;
        end else if (!stat.walk_more) begin
          state_next = S_TALLY_INIT;
        end
      end
      S_PLACE: begin
        cmd.op     = DP_PLACE;
        state_next = S_MARK;
      end
      S_MARK: begin
        cmd.op     = DP_MARK;
        // an exact fit leaves the roving pointer to skip over used blocks
        state_next = stat.rem_zero ? S_SCAN : S_TALLY_INIT;
      end
      S_SCAN: begin
        cmd.op = DP_SCAN;
        if (!stat.scan_more) begin
          state_next = S_TALLY_INIT;
        end
      end
      S_REL: begin
        cmd.op     = DP_REL;
        state_next = S_TALLY_INIT;
      end
      S_TALLY_INIT: begin
        cmd.op     = DP_TALLY_INIT;
        state_next = S_TALLY;
      end
      S_TALLY: begin
        cmd.op = DP_TALLY;
        if (!stat.walk_more) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

// File: src/bth_checker.sv
`include "boundary_tag_heap_allocator_core_macros.svh"

module bth_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  status,
  input logic [13:0] granted_address
);
  import bth_pkg::*;

  `BTH_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `BTH_ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done not a single cycle ending busy")
  `BTH_ASSERT_NOW(a_done_in_busy, done, busy, "done outside a busy period")
  `BTH_ASSERT_NOW(a_fail_no_addr, done && status != ST_OK, granted_address == 14'd0,
                  "failed request returned an address")

endmodule

bind boundary_tag_heap_allocator_core bth_checker u_bth_checker (.*);
